// ===== rtl/nrph_pkg.sv =====
package nrph_pkg;

  // pi/4 as an unsigned Q0.64 fraction, the scale for the sine argument.
  localparam logic [63:0] PI4_Q64 = 64'hC90FDAA22168C235;

  // Request codes.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_CAST = 1'b1;

  // Configuration register indexes.
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_RAY_COUNT    = 1'b1;

  // Number of odd-power terms after x in the sine series.
  localparam logic [3:0] SERIES_TERMS = 4'd12;

  // Divisor (2n)(2n+1) that turns term n-1 of the sine series into term n.
  function automatic logic [9:0] series_div(input logic [3:0] n);
    logic [9:0] d;
    case (n)
      4'd1:    d = 10'd6;
      4'd2:    d = 10'd20;
      4'd3:    d = 10'd42;
      4'd4:    d = 10'd72;
      4'd5:    d = 10'd110;
      4'd6:    d = 10'd156;
      4'd7:    d = 10'd210;
      4'd8:    d = 10'd272;
      4'd9:    d = 10'd342;
      4'd10:   d = 10'd420;
      4'd11:   d = 10'd506;
      4'd12:   d = 10'd600;
      default: d = 10'd1;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/nrph_ram.sv =====
module nrph_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/nearest_ray_polygon_hit_top.sv =====
// Nearest ray crossing against a closed polygon map held in an internal RAM.
// Input items carry either a vertex load (req_type 0) or a ray cast (req_type 1).
// A load writes one vertex and gives no result item. A cast
// gives exactly one result item: the nearest crossing point, its segment and
// the echoed ray number, or hit low with zero coordinates when nothing is hit.
// The block takes one item at a time; in_stall is high while a cast runs.
// A cast is built on one shared 34x34 multiplier and one shared restoring
// divider that retires one quotient bit per cycle: the two sine series take
// 12 divides of 64 steps each, and every crossing the ray makes takes two
// 84-step divides to place the point.
// A finished result sits in the output register until taken; while out_stall
// is high the next item is still accepted, and a later cast waits at its end.
// Configuration writes (vertex_count, ray_count) are always ready and are
// meant to happen while the block is idle. Synchronous reset clears the
// control state, sets vertex_count to 0 and ray_count to 360, and drops
// out_valid; the vertex RAM is not cleared.
module nearest_ray_polygon_hit_top #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [9:0]         vertex_index,
  input  logic signed [31:0] vertex_x,
  input  logic signed [31:0] vertex_y,
  input  logic signed [31:0] pose_x,
  input  logic signed [31:0] pose_y,
  input  logic [15:0]        pose_heading,
  input  logic [11:0]        ray_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic signed [31:0] hit_x,
  output logic signed [31:0] hit_y,
  output logic [9:0]         hit_segment,
  output logic [11:0]        ray_number
);
  import nrph_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DIV    = 5'd1;
  localparam logic [4:0] S_MUL    = 5'd2;
  localparam logic [4:0] S_MULW   = 5'd3;
  localparam logic [4:0] A_ANG    = 5'd4;
  localparam logic [4:0] SN_START = 5'd5;
  localparam logic [4:0] SN_X     = 5'd6;
  localparam logic [4:0] SN_X2    = 5'd7;
  localparam logic [4:0] SN_T     = 5'd8;
  localparam logic [4:0] SN_D     = 5'd9;
  localparam logic [4:0] SN_END   = 5'd10;
  localparam logic [4:0] SG_R0    = 5'd11;
  localparam logic [4:0] SG_R0W   = 5'd12;
  localparam logic [4:0] SG_RB    = 5'd13;
  localparam logic [4:0] SG_E     = 5'd14;
  localparam logic [4:0] M1       = 5'd15;
  localparam logic [4:0] M2       = 5'd16;
  localparam logic [4:0] M3       = 5'd17;
  localparam logic [4:0] M4       = 5'd18;
  localparam logic [4:0] M5       = 5'd19;
  localparam logic [4:0] M6       = 5'd20;
  localparam logic [4:0] M7       = 5'd21;
  localparam logic [4:0] SX_DIV   = 5'd22;
  localparam logic [4:0] SX_END   = 5'd23;
  localparam logic [4:0] SY_DIV   = 5'd24;
  localparam logic [4:0] SY_END   = 5'd25;
  localparam logic [4:0] D1       = 5'd26;
  localparam logic [4:0] D2       = 5'd27;
  localparam logic [4:0] D3       = 5'd28;
  localparam logic [4:0] SG_NEXT  = 5'd29;
  localparam logic [4:0] S_FIN    = 5'd30;

  logic [4:0]  state, ret;
  logic [10:0] vertex_count;
  logic [12:0] ray_count;

  logic signed [31:0] px, py;
  logic [15:0]        heading;
  logic [11:0]        ri;
  logic [15:0]        ang;
  logic               pass, neg;
  logic signed [17:0] dx, dy;

  // Shared multiplier and the 128-bit accumulator for wide products.
  logic [63:0]        m_a, m_b;
  logic [1:0]         k;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod;
  logic               pp_go, pp_clr;
  logic [1:0]         pp_sh;
  logic [127:0]       acc;

  // Shared restoring divider.
  logic [50:0] dv_rem, dv_den;
  logic [83:0] dv_num;
  logic [63:0] dv_q;
  logic [6:0]  dv_cnt;
  logic [51:0] dv_r, dv_sub;
  logic        dv_ge;

  // Sine series.
  logic [63:0] x2, sum, snd;
  logic [3:0]  sn;
  logic [15:0] arg;
  logic [14:0] rr;
  logic [17:0] sv;
  logic signed [17:0] sres;

  // Segment walk.
  logic [CW-1:0]      n_seg, n_eff, j, j_inc;
  logic               seg_last;
  logic signed [31:0] v0x, v0y, ax, ay, bx, by, bxv, byv;
  logic signed [32:0] ex, ey, wx, wy;
  logic [31:0]        ex_mag, ey_mag;
  logic signed [50:0] den, nu, nabs;
  logic [50:0]        dabs, den_abs, nu_abs;
  logic signed [67:0] t1;
  logic               seg_pass;
  logic signed [31:0] hx, hy;
  logic signed [32:0] ddx, ddy;
  logic               rnd, sc_neg;
  logic [33:0]        rq;
  logic signed [34:0] off, hsum;
  logic signed [31:0] sc_base;
  logic [65:0]        range_sq, best_dist;
  logic               found;
  logic signed [31:0] best_x, best_y;
  logic [CW-1:0]      best_seg;

  // RAM holds {x, y} of each vertex.
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [63:0]   ram_rdata;
  logic          in_take;

  nrph_ram #(.WIDTH(64), .DEPTH(MAX_VERTICES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(vertex_index)),
    .wdata ({vertex_x, vertex_y}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && (state == S_IDLE);
  assign ram_we    = in_take && (req_type == REQ_LOAD) &&
                     (32'(vertex_index) < MAX_VERTICES);

  assign n_eff    = ({21'b0, vertex_count} > 32'(MAX_VERTICES)) ?
                    CW'(MAX_VERTICES) : CW'(vertex_count);
  assign j_inc    = j + CW'(1);
  assign seg_last = (j_inc == n_seg);

  always_comb begin
    case (state)
      SG_RB:   ram_raddr = AW'(j_inc);
      default: ram_raddr = '0;
    endcase
  end

  // Multiplier operand selection.
  always_comb begin
    case (state)
      S_MUL: begin
        mul_a = $signed({2'b0, k[1] ? m_a[63:32] : m_a[31:0]});
        mul_b = $signed({2'b0, k[0] ? m_b[63:32] : m_b[31:0]});
      end
      M1: begin
        mul_a = {{16{dx[17]}}, dx};
        mul_b = {ey[32], ey};
      end
      M2: begin
        mul_a = {{16{dy[17]}}, dy};
        mul_b = {ex[32], ex};
      end
      M3: begin
        mul_a = {wx[32], wx};
        mul_b = {{16{dy[17]}}, dy};
      end
      M4: begin
        mul_a = {wy[32], wy};
        mul_b = {{16{dx[17]}}, dx};
      end
      M5: begin
        mul_a = {wx[32], wx};
        mul_b = {ey[32], ey};
      end
      M6: begin
        mul_a = {wy[32], wy};
        mul_b = {ex[32], ex};
      end
      D1: begin
        mul_a = {ddx[32], ddx};
        mul_b = {ddx[32], ddx};
      end
      D2: begin
        mul_a = {ddy[32], ddy};
        mul_b = {ddy[32], ddy};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign dv_r   = {dv_rem, dv_num[83]};
  assign dv_sub = dv_r - {1'b0, dv_den};
  assign dv_ge  = (dv_r >= {1'b0, dv_den});

  assign arg  = pass ? ang : (ang + 16'h4000);
  assign rr   = arg[14] ? (15'd16384 - {1'b0, arg[13:0]}) : {1'b0, arg[13:0]};
  assign snd  = sum + 64'h0000_2000_0000_0000;
  assign sv   = snd[63:46];
  assign sres = neg ? -$signed(sv) : $signed(sv);

  assign bxv    = seg_last ? v0x : $signed(ram_rdata[63:32]);
  assign byv    = seg_last ? v0y : $signed(ram_rdata[31:0]);
  assign ex_mag = ex[32] ? 32'(-ex) : 32'(ex);
  assign ey_mag = ey[32] ? 32'(-ey) : 32'(ey);

  // A segment is crossed when den is nonzero and, after making den positive,
  // w x e >= 0 and 0 <= w x d <= den.
  assign dabs     = den[50] ? 51'(-den) : 51'(den);
  assign nabs     = den[50] ? -nu : nu;
  assign seg_pass = (den != '0) && (den[50] ? (t1 <= prod) : (t1 >= prod)) &&
                    !nabs[50] && ($unsigned(nabs) <= dabs);

  // Rounded offset along the segment, halves away from zero.
  assign rnd     = (dv_rem >= (den_abs - dv_rem));
  assign rq      = dv_q[33:0] + 34'(rnd);
  assign sc_neg  = (state == SY_END) ? ey[32] : ex[32];
  assign sc_base = (state == SY_END) ? ay : ax;
  assign off     = sc_neg ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
  assign hsum    = {{3{sc_base[31]}}, sc_base} + off;

  assign ddx      = {hx[31], hx} - {px[31], px};
  assign ddy      = {hy[31], hy} - {py[31], py};
  assign range_sq = 66'(t1 + prod);

  always_ff @(posedge clk) begin
    prod   <= mul_a * mul_b;
    pp_clr <= (k == 2'd0);
    pp_sh  <= {1'b0, k[1]} + {1'b0, k[0]};
    if (pp_go) begin
      acc <= (pp_clr ? 128'd0 : acc) + ({64'd0, prod[63:0]} << {pp_sh, 5'd0});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      vertex_count <= 11'd0;
      ray_count    <= 13'd360;
      pp_go        <= 1'b0;
    end else begin
      pp_go <= (state == S_MUL);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_VERTEX_COUNT) begin
          vertex_count <= cfg_data[10:0];
        end else begin
          ray_count <= cfg_data;
        end
      end
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_take && (req_type == REQ_CAST)) begin
            px       <= pose_x;
            py       <= pose_y;
            heading  <= pose_heading;
            ri       <= ray_index;
            n_seg    <= n_eff;
            found    <= 1'b0;
            best_x   <= '0;
            best_y   <= '0;
            best_seg <= '0;
            // The ray angle offset is ray_index * 65536 / ray_count.
            dv_num   <= {ray_index, 16'h0, 56'h0};
            dv_den   <= (ray_count == 13'd0) ? 51'd1 : 51'(ray_count);
            dv_rem   <= '0;
            dv_q     <= '0;
            dv_cnt   <= 7'd28;
            ret      <= A_ANG;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          dv_rem <= dv_ge ? dv_sub[50:0] : dv_r[50:0];
          dv_q   <= {dv_q[62:0], dv_ge};
          dv_num <= {dv_num[82:0], 1'b0};
          dv_cnt <= dv_cnt - 7'd1;
          if (dv_cnt == 7'd1) begin
            state <= ret;
          end
        end
        S_MUL: begin
          k <= k + 2'd1;
          if (k == 2'd3) begin
            state <= S_MULW;
          end
        end
        S_MULW: begin
          state <= ret;
        end
        A_ANG: begin
          ang   <= heading + dv_q[15:0] + 16'h8000;
          pass  <= 1'b0;
          state <= SN_START;
        end
        SN_START: begin
          neg   <= arg[15];
          m_a   <= {rr, 49'd0};
          m_b   <= PI4_Q64;
          k     <= 2'd0;
          ret   <= SN_X;
          state <= S_MUL;
        end
        SN_X: begin
          m_a   <= acc[127:64];
          m_b   <= acc[127:64];
          sum   <= acc[127:64];
          k     <= 2'd0;
          ret   <= SN_X2;
          state <= S_MUL;
        end
        SN_X2: begin
          x2    <= acc[125:62];
          m_b   <= acc[125:62];
          sn    <= 4'd1;
          k     <= 2'd0;
          ret   <= SN_T;
          state <= S_MUL;
        end
        SN_T: begin
          dv_num <= {acc[125:62], 20'h0};
          dv_den <= 51'(series_div(sn));
          dv_rem <= '0;
          dv_q   <= '0;
          dv_cnt <= 7'd64;
          ret    <= SN_D;
          state  <= S_DIV;
        end
        SN_D: begin
          sum <= sn[0] ? (sum - dv_q) : (sum + dv_q);
          if (sn == SERIES_TERMS) begin
            state <= SN_END;
          end else begin
            sn    <= sn + 4'd1;
            m_a   <= dv_q;
            m_b   <= x2;
            k     <= 2'd0;
            ret   <= SN_T;
            state <= S_MUL;
          end
        end
        SN_END: begin
          if (!pass) begin
            dx    <= sres;
            pass  <= 1'b1;
            state <= SN_START;
          end else begin
            dy    <= sres;
            state <= SG_R0;
          end
        end
        SG_R0: begin
          state <= SG_R0W;
        end
        SG_R0W: begin
          v0x <= $signed(ram_rdata[63:32]);
          v0y <= $signed(ram_rdata[31:0]);
          ax  <= $signed(ram_rdata[63:32]);
          ay  <= $signed(ram_rdata[31:0]);
          j   <= '0;
          state <= (n_seg == '0) ? S_FIN : SG_RB;
        end
        SG_RB: begin
          state <= SG_E;
        end
        SG_E: begin
          bx    <= bxv;
          by    <= byv;
          ex    <= {bxv[31], bxv} - {ax[31], ax};
          ey    <= {byv[31], byv} - {ay[31], ay};
          wx    <= {ax[31], ax} - {px[31], px};
          wy    <= {ay[31], ay} - {py[31], py};
          state <= M1;
        end
        M1: state <= M2;
        M2: begin
          t1    <= prod;
          state <= M3;
        end
        M3: begin
          den   <= 51'(t1 - prod);
          state <= M4;
        end
        M4: begin
          t1    <= prod;
          state <= M5;
        end
        M5: begin
          nu    <= 51'(t1 - prod);
          state <= M6;
        end
        M6: begin
          t1    <= prod;
          state <= M7;
        end
        M7: begin
          den_abs <= dabs;
          nu_abs  <= $unsigned(nabs);
          if (seg_pass) begin
            m_a   <= {13'd0, $unsigned(nabs)};
            m_b   <= {32'd0, ex_mag};
            k     <= 2'd0;
            ret   <= SX_DIV;
            state <= S_MUL;
          end else begin
            state <= SG_NEXT;
          end
        end
        SX_DIV, SY_DIV: begin
          dv_num <= acc[83:0];
          dv_den <= den_abs;
          dv_rem <= '0;
          dv_q   <= '0;
          dv_cnt <= 7'd84;
          ret    <= (state == SX_DIV) ? SX_END : SY_END;
          state  <= S_DIV;
        end
        SX_END: begin
          hx    <= hsum[31:0];
          m_a   <= {13'd0, nu_abs};
          m_b   <= {32'd0, ey_mag};
          k     <= 2'd0;
          ret   <= SY_DIV;
          state <= S_MUL;
        end
        SY_END: begin
          hy    <= hsum[31:0];
          state <= D1;
        end
        D1: state <= D2;
        D2: begin
          t1    <= prod;
          state <= D3;
        end
        D3: begin
          if (!found || (range_sq < best_dist)) begin
            found     <= 1'b1;
            best_dist <= range_sq;
            best_x    <= hx;
            best_y    <= hy;
            best_seg  <= j;
          end
          state <= SG_NEXT;
        end
        SG_NEXT: begin
          ax    <= bx;
          ay    <= by;
          j     <= j_inc;
          state <= seg_last ? S_FIN : SG_RB;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            hit         <= found;
            hit_x       <= best_x;
            hit_y       <= best_y;
            hit_segment <= 10'(best_seg);
            ray_number  <= ri;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/ray_hit_monitor.sv =====
`timescale 1ns / 100ps

module ray_hit_monitor (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               req_type,
  input  logic [9:0]         vertex_index,
  input  logic signed [31:0] vertex_x,
  input  logic signed [31:0] vertex_y,
  input  logic signed [31:0] pose_x,
  input  logic signed [31:0] pose_y,
  input  logic [15:0]        pose_heading,
  input  logic [11:0]        ray_index,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               hit,
  input  logic signed [31:0] hit_x,
  input  logic signed [31:0] hit_y,
  input  logic [9:0]         hit_segment,
  input  logic [11:0]        ray_number,
  output int                 errors,
  output int                 pending
);
  import nrph_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [31:0] x;
    logic [31:0] y;
    logic [9:0]  seg;
    logic [11:0] ray;
  } crossing_t;

  longint    map_x [1024];
  longint    map_y [1024];
  logic [10:0] n_vertices;
  logic [12:0] n_rays;
  crossing_t pending_hits [$];

  // Sine of r*pi/32768 for r in 0..16384, rounded to Q1.16.
  function automatic longint quarter_sin(int unsigned r);
    logic [127:0] p;
    logic [63:0]  x, x2, term, sum;
    p = {64'd0, 64'(r) << 49} * {64'd0, PI4_Q64};
    x = p[127:64];
    p = {64'd0, x} * {64'd0, x};
    x2 = p[125:62];
    term = x;
    sum = x;
    for (int n = 1; n <= 12; n++) begin
      p = {64'd0, term} * {64'd0, x2};
      term = p[125:62] / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    sum = sum + (64'd1 << 45);
    return longint'(sum >> 46);
  endfunction

  function automatic longint turn_sin(logic [15:0] a);
    longint m;
    m = a[14] ? quarter_sin(16384 - a[13:0]) : quarter_sin(a[13:0]);
    return a[15] ? -m : m;
  endfunction

  // round(num*e/den) with halves away from zero; 0 <= num <= den.
  function automatic longint scaled_offset(longint num, longint e, longint den);
    logic [127:0] prod, q, rm, d;
    longint mag;
    mag = (e < 0) ? -e : e;
    d = {64'd0, 64'(den)};
    prod = {64'd0, 64'(num)} * {64'd0, 64'(mag)};
    q = prod / d;
    rm = prod % d;
    if (rm >= d - rm) q = q + 1;
    return (e < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic crossing_t cast_ray(longint px, longint py, logic [15:0] heading,
                                         logic [11:0] ri);
    crossing_t res;
    int unsigned rc, n, k;
    logic [15:0] ang;
    longint dx, dy, ax, ay, ex, ey, wx, wy, den, nu, hx, hy, ddx, ddy;
    logic signed [127:0] c1, c2, cr, sx, sy;
    logic [127:0] range_sq, best;
    logic found;
    found = 0;
    best = '0;
    res = '0;
    res.ray = ri;
    rc = (n_rays == 0) ? 1 : n_rays;
    ang = 16'(heading + (int'(ri) * 65536) / rc + 32768);
    dx = turn_sin(ang + 16'd16384);
    dy = turn_sin(ang);
    n = (n_vertices > 1024) ? 1024 : n_vertices;
    for (int j = 0; j < n; j++) begin
      k = (j + 1 >= n) ? 0 : j + 1;
      ax = map_x[j];
      ay = map_y[j];
      ex = map_x[k] - ax;
      ey = map_y[k] - ay;
      wx = ax - px;
      wy = ay - py;
      den = dx * ey - dy * ex;
      nu = wx * dy - wy * dx;
      if (den == 0) continue;
      c1 = wx;
      c1 = c1 * ey;
      c2 = wy;
      c2 = c2 * ex;
      cr = c1 - c2;
      if (den < 0) begin
        den = -den;
        nu = -nu;
        cr = -cr;
      end
      if (cr < 0 || nu < 0 || nu > den) continue;
      hx = ax + scaled_offset(nu, ex, den);
      hy = ay + scaled_offset(nu, ey, den);
      ddx = hx - px;
      ddy = hy - py;
      sx = ddx;
      sy = ddy;
      range_sq = sx * sx + sy * sy;
      if (!found || range_sq < best) begin
        found = 1;
        best = range_sq;
        res.hit = 1;
        res.x = hx[31:0];
        res.y = hy[31:0];
        res.seg = 10'(j);
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    crossing_t want;
    if (rst) begin
      n_vertices = 0;
      n_rays = 360;
      pending_hits.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_VERTEX_COUNT) n_vertices = cfg_data[10:0];
        else n_rays = cfg_data;
      end
      if (in_valid && !in_stall) begin
        if (req_type == REQ_LOAD) begin
          map_x[vertex_index] = vertex_x;
          map_y[vertex_index] = vertex_y;
        end else begin
          pending_hits.insert(pending_hits.size(),
                              cast_ray(pose_x, pose_y, pose_heading, ray_index));
        end
      end
      if (out_valid && !out_stall) begin
        if (pending_hits.size() == 0) begin
          $display("%0t: result item with none expected (ray %0d)", $time, ray_number);
          errors++;
        end else begin
          want = pending_hits.pop_front();
          if (hit !== want.hit) begin
            $display("%0t: hit expected %0d got %0d", $time, want.hit, hit);
            errors++;
          end
          if (hit_x !== want.x) begin
            $display("%0t: hit_x expected %0d got %0d", $time,
                     $signed(want.x), hit_x);
            errors++;
          end
          if (hit_y !== want.y) begin
            $display("%0t: hit_y expected %0d got %0d", $time,
                     $signed(want.y), hit_y);
            errors++;
          end
          if (hit_segment !== want.seg) begin
            $display("%0t: hit_segment expected %0d got %0d", $time, want.seg,
                     hit_segment);
            errors++;
          end
          if (ray_number !== want.ray) begin
            $display("%0t: ray_number expected %0d got %0d", $time, want.ray,
                     ray_number);
            errors++;
          end
        end
      end
    end
    pending = pending_hits.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import nrph_pkg::*;

  localparam int CYCLE_LIMIT = 10000000;
  localparam int MAX_I = 2147483647;
  localparam int MIN_I = -2147483647 - 1;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_index;
  logic [12:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               req_type;
  logic [9:0]         vertex_index;
  logic signed [31:0] vertex_x;
  logic signed [31:0] vertex_y;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic [15:0]        pose_heading;
  logic [11:0]        ray_index;
  logic               out_valid;
  logic               out_stall;
  logic               hit;
  logic signed [31:0] hit_x;
  logic signed [31:0] hit_y;
  logic [9:0]         hit_segment;
  logic [11:0]        ray_number;
  int                 errors;
  int                 pending;
  logic               calm;
  int                 stall_left;
  int                 cycles;

  nearest_ray_polygon_hit_top dut (.*);

  ray_hit_monitor mon (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Result side: a fresh stall length is drawn for every item taken.
  initial begin
    out_stall <= 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_valid && !out_stall) begin
          stall_left = calm ? 0 : $urandom_range(0, 10);
          if (stall_left > 0) out_stall <= 1;
        end else if (stall_left > 0) begin
          stall_left--;
          if (stall_left == 0) out_stall <= 0;
        end
      end
    end
  end

  function automatic int clamp32(longint v);
    if (v > MAX_I) return MAX_I;
    if (v < MIN_I) return MIN_I;
    return int'(v);
  endfunction

  task automatic send(logic kind, logic [9:0] idx, int vx, int vy, int px, int py,
                      logic [15:0] hd, logic [11:0] ri);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    req_type <= kind;
    vertex_index <= idx;
    vertex_x <= vx;
    vertex_y <= vy;
    pose_x <= px;
    pose_y <= py;
    pose_heading <= hd;
    ray_index <= ri;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic load_vertex(int idx, int x, int y);
    send(REQ_LOAD, 10'(idx), x, y, $urandom, $urandom, 16'($urandom), 12'($urandom));
  endtask

  task automatic cast(int px, int py, int hd, int ri);
    send(REQ_CAST, 10'($urandom), $urandom, $urandom, px, py, 16'(hd), 12'(ri));
  endtask

  // Wait for every outstanding result, then let a possible load finish.
  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0 || in_stall) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    settle();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= 13'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  initial begin
    int rc_pick [8];
    longint cx, cy, rad;
    int n, rc;
    int vx, vy, lx, ly;
    rc_pick = '{0, 1, 2, 3, 360, 4096, 8191, 1000};
    calm = 0;
    lx = 0;
    ly = 0;
    rst <= 1;
    cfg_valid <= 0;
    cfg_index <= 0;
    cfg_data <= 0;
    in_valid <= 0;
    req_type <= 0;
    vertex_index <= 0;
    vertex_x <= 0;
    vertex_y <= 0;
    pose_x <= 0;
    pose_y <= 0;
    pose_heading <= 0;
    ray_index <= 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // With no vertices in use nothing can be hit.
    cast(0, 0, 0, 0);
    // A square at the corners of the coordinate range.
    load_vertex(0, MIN_I, MIN_I);
    load_vertex(1, MAX_I, MIN_I);
    load_vertex(2, MAX_I, MAX_I);
    load_vertex(3, MIN_I, MAX_I);
    write_reg(REG_VERTEX_COUNT, 4);
    cast(0, 0, 0, 0);
    cast(0, 0, 16384, 0);
    cast(0, 0, 0, 45);
    cast(0, 0, 65535, 4095);
    cast(MAX_I, MAX_I, 32768, 0);
    cast(MAX_I, MAX_I, 0, 45);
    cast(MIN_I, 0, 0, 180);
    write_reg(REG_RAY_COUNT, 0);
    cast(0, 0, 12345, 4095);
    write_reg(REG_RAY_COUNT, 8191);
    cast(0, 0, 0, 2047);
    // A single vertex makes a zero-length segment; two make a segment both ways.
    write_reg(REG_VERTEX_COUNT, 1);
    cast(MAX_I, MAX_I, 0, 0);
    write_reg(REG_VERTEX_COUNT, 2);
    write_reg(REG_RAY_COUNT, 4);
    cast(0, 0, 0, 1);
    cast(0, 0, 0, 3);
    cast(0, 1000, 0, 3);

    // Random polygons; each phase ends by waiting for every result.
    for (int ph = 0; ph < 16; ph++) begin
      calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(1, 12);
      rad = longint'(1) << $urandom_range(8, 29);
      cx = $signed($urandom) >>> $urandom_range(1, 8);
      cy = $signed($urandom) >>> $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        if (i > 0 && $urandom_range(0, 9) == 0) begin
          vx = lx;
          vy = ly;
        end else begin
          vx = clamp32(cx + longint'($urandom_range(0, 2 * 65535)) * rad / 65535 - rad);
          vy = clamp32(cy + longint'($urandom_range(0, 2 * 65535)) * rad / 65535 - rad);
        end
        load_vertex(i, vx, vy);
        lx = vx;
        ly = vy;
      end
      repeat ($urandom_range(2, 6)) load_vertex($urandom_range(n, 1023), $urandom, $urandom);
      rc = rc_pick[$urandom_range(0, 7)];
      if (rc == 1000) rc = $urandom_range(1, 4096);
      write_reg(REG_RAY_COUNT, rc);
      write_reg(REG_VERTEX_COUNT, n);
      for (int c = 0; c < 20; c++) begin
        if ($urandom_range(0, 7) == 0) begin
          load_vertex($urandom_range(0, n - 1), clamp32(cx + $signed($urandom) % rad),
                      clamp32(cy + $signed($urandom) % rad));
        end
        cast(clamp32(cx + $signed($urandom) % (rad / 2 + 1)),
             clamp32(cy + $signed($urandom) % (rad / 2 + 1)),
             $urandom, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, rc));
      end
      settle();
    end

    settle();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
